// ===== hw/rtl/dtq_pkg.sv =====
// shared types and constants of the deadline timer queue
package dtq_pkg;

  localparam int ID_W     = 16;
  localparam int TAG_W    = 32;
  localparam int FIELD_TW = 48;

  typedef enum logic [1:0] {
    KIND_PUSH_OK   = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_SUMMARY   = 2'd2,
    KIND_PUSH_FULL = 2'd3
  } kind_t;

  typedef enum logic {
    CMD_PUSH   = 1'b0,
    CMD_EXPIRE = 1'b1
  } cmd_t;

endpackage

// ===== hw/rtl/dtq_if.sv =====
// valid/ready channels of the deadline timer queue
interface dtq_in_if;
  import dtq_pkg::*;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [ID_W-1:0]     tmr_id;
  logic [FIELD_TW-1:0] deadline;
  logic [FIELD_TW-1:0] now_ms;

  modport source (output valid, cmd, tmr_id, deadline, now_ms, input ready);
  modport sink (input valid, cmd, tmr_id, deadline, now_ms, output ready);
endinterface

interface dtq_out_if;
  import dtq_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [ID_W-1:0]     out_timer_id;
  logic [FIELD_TW-1:0] out_deadline;
  logic                arm_request;
  logic [FIELD_TW-1:0] next_deadline;
  logic                queue_empty;
  logic                last;

  modport source (output valid, kind, out_timer_id, out_deadline, arm_request,
                  next_deadline, queue_empty, last, input ready);
  modport sink (input valid, kind, out_timer_id, out_deadline, arm_request,
                next_deadline, queue_empty, last, output ready);
endinterface

// ===== hw/rtl/dtq_heap_mem.sv =====
// heap storage: one write port, one read port with registered data
module dtq_heap_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int EW    = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata
);

  logic [EW-1:0] mem_r [DEPTH];
  logic [EW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dtq_cmp.sv =====
// shared ordering unit: deadline first, then serial order tag
module dtq_cmp #(
  parameter int TB = 48,
  parameter int EW = 96
) (
  input  logic [EW-1:0] a,
  input  logic [EW-1:0] b,
  output logic          a_first
);
  import dtq_pkg::*;

  logic [TB-1:0]    a_dl, b_dl;
  logic [TAG_W-1:0] tag_diff;

  assign a_dl     = a[EW-1 -: TB];
  assign b_dl     = b[EW-1 -: TB];
  assign tag_diff = a[TAG_W-1:0] - b[TAG_W-1:0];

  always_comb begin
    if (a_dl != b_dl) begin
      a_first = a_dl < b_dl;
    end else begin
      a_first = tag_diff[TAG_W-1];
    end
  end

endmodule

// ===== hw/rtl/deadline_timer_queue.sv =====
// min-heap timer queue: push and expire over a shared compare unit and one memory
// push: the entry climbs the heap, each later parent moving down into the hole
// expire: each due root is output, the last entry refills the root and sinks past
// the earlier child; a full output register stalls the result states
// one item at a time; the heap memory's single read port sets the pace
// results leave through an output register; synchronous active-low reset empties the queue
module deadline_timer_queue #(
  parameter int CAPACITY  = 32,
  parameter int TIME_BITS = 48
) (
  input  logic     clk,
  input  logic     rst_n,
  dtq_in_if.sink   in_ch,
  dtq_out_if.source out_ch
);
  import dtq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int TB = TIME_BITS;
  localparam int EW = TB + ID_W + TAG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_PUSH_OUT, S_FULL_OUT, S_EXP_CHK, S_EXP_OUT,
    S_DN_LAST, S_DN_L_RD, S_DN_R_RD, S_DN_CMP1, S_DN_CMP2, S_SUM_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [TAG_W-1:0]  ictr_r, ictr_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     cidx_r, cidx_nxt;
  logic [EW-1:0]     e_r, e_nxt;
  logic [EW-1:0]     c_r, c_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic              arm_r, arm_nxt;
  logic [TB-1:0]     now_r, now_nxt;
  logic [TB-1:0]     head_dl_r, head_dl_nxt;
  logic [ID_W-1:0]   head_id_r, head_id_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               kind_r, kind_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [FIELD_TW-1:0] odl_r, odl_nxt;
  logic                oarm_r, oarm_nxt;
  logic [FIELD_TW-1:0] onext_r, onext_nxt;
  logic                oempty_r, oempty_nxt;
  logic                olast_r, olast_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic [EW-1:0] cmp_a, cmp_b;
  logic          cmp_first;

  logic [TB-1:0]       in_dl, in_now;
  logic                slot_free;
  logic [AW-1:0]       parent;
  logic [CW:0]         l_idx, r_idx;
  logic [FIELD_TW-1:0] head_dl_out;

  dtq_heap_mem #(.DEPTH(CAPACITY), .AW(AW), .EW(EW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dtq_cmp #(.TB(TB), .EW(EW)) u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .a_first (cmp_first)
  );

  assign in_dl       = TB'(64'(in_ch.deadline));
  assign in_now      = TB'(64'(in_ch.now_ms));
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign parent      = AW'((pos_r - AW'(1)) >> 1);
  assign l_idx       = (CW + 1)'({pos_r, 1'b1});
  assign r_idx       = l_idx + (CW + 1)'(1);
  assign head_dl_out = FIELD_TW'(64'(head_dl_r));

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    case (state_r)
      S_UP_CMP: begin
        cmp_a = e_r;
        cmp_b = mem_rdata;
      end
      S_DN_CMP1: begin
        cmp_a = mem_rdata;
        cmp_b = c_r;
      end
      default: begin
        cmp_a = c_r;
        cmp_b = e_r;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ictr_nxt   = ictr_r;
    pos_nxt    = pos_r;
    cidx_nxt   = cidx_r;
    e_nxt      = e_r;
    c_nxt      = c_r;
    rvalid_nxt = rvalid_r;
    arm_nxt    = arm_r;
    now_nxt    = now_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    oid_nxt       = oid_r;
    odl_nxt       = odl_r;
    oarm_nxt      = oarm_r;
    onext_nxt     = onext_r;
    oempty_nxt    = oempty_r;
    olast_nxt     = olast_r;

    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = e_r;
    mem_raddr = parent;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.cmd == CMD_PUSH) begin
            e_nxt = {in_dl, in_ch.tmr_id, ictr_r};
            if (cnt_r == CW'(CAPACITY)) begin
              state_nxt = S_FULL_OUT;
            end else begin
              arm_nxt   = (cnt_r == '0) || (in_dl < head_dl_r);
              ictr_nxt  = ictr_r + TAG_W'(1);
              pos_nxt   = cnt_r[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            now_nxt   = in_now;
            state_nxt = S_EXP_CHK;
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_PUSH_OUT;
        end else begin
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_first) begin
          // parent moves down into the hole
          mem_wdata = mem_rdata;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_PUSH_OUT;
        end
      end
      S_PUSH_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_PUSH_OK;
          oid_nxt       = e_r[TAG_W +: ID_W];
          odl_nxt       = FIELD_TW'(64'(e_r[EW-1 -: TB]));
          oarm_nxt      = arm_r;
          onext_nxt     = head_dl_out;
          oempty_nxt    = 1'b0;
          olast_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FULL_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_PUSH_FULL;
          oid_nxt       = e_r[TAG_W +: ID_W];
          odl_nxt       = FIELD_TW'(64'(e_r[EW-1 -: TB]));
          oarm_nxt      = 1'b0;
          onext_nxt     = (cnt_r != '0) ? head_dl_out : '0;
          oempty_nxt    = (cnt_r == '0);
          olast_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EXP_CHK: begin
        if (cnt_r != '0 && head_dl_r <= now_r) begin
          state_nxt = S_EXP_OUT;
        end else begin
          state_nxt = S_SUM_OUT;
        end
      end
      S_EXP_OUT: begin
        mem_raddr = AW'(cnt_r - CW'(1));
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_EXPIRED;
          oid_nxt       = head_id_r;
          odl_nxt       = head_dl_out;
          oarm_nxt      = 1'b0;
          onext_nxt     = '0;
          oempty_nxt    = 1'b0;
          olast_nxt     = 1'b0;
          cnt_nxt       = cnt_r - CW'(1);
          state_nxt     = (cnt_r > CW'(1)) ? S_DN_LAST : S_EXP_CHK;
        end
      end
      S_DN_LAST: begin
        // last entry refills the root hole
        e_nxt     = mem_rdata;
        pos_nxt   = '0;
        state_nxt = S_DN_L_RD;
      end
      S_DN_L_RD: begin
        mem_raddr = l_idx[AW-1:0];
        if (l_idx >= {1'b0, cnt_r}) begin
          mem_we    = 1'b1;
          state_nxt = S_EXP_CHK;
        end else begin
          state_nxt = S_DN_R_RD;
        end
      end
      S_DN_R_RD: begin
        mem_raddr  = r_idx[AW-1:0];
        c_nxt      = mem_rdata;
        cidx_nxt   = l_idx[AW-1:0];
        rvalid_nxt = r_idx < {1'b0, cnt_r};
        state_nxt  = S_DN_CMP1;
      end
      S_DN_CMP1: begin
        if (rvalid_r && cmp_first) begin
          c_nxt    = mem_rdata;
          cidx_nxt = cidx_r + AW'(1);
        end
        state_nxt = S_DN_CMP2;
      end
      S_DN_CMP2: begin
        mem_we = 1'b1;
        if (cmp_first) begin
          mem_wdata = c_r;
          pos_nxt   = cidx_r;
          state_nxt = S_DN_L_RD;
        end else begin
          state_nxt = S_EXP_CHK;
        end
      end
      S_SUM_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_SUMMARY;
          oid_nxt       = '0;
          odl_nxt       = '0;
          oarm_nxt      = (cnt_r != '0);
          onext_nxt     = (cnt_r != '0) ? head_dl_out : '0;
          oempty_nxt    = (cnt_r == '0);
          olast_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // root copy kept in flops so pushes and expire checks skip a read
  always_comb begin
    head_dl_nxt = head_dl_r;
    head_id_nxt = head_id_r;
    if (mem_we && mem_waddr == '0) begin
      head_dl_nxt = mem_wdata[EW-1 -: TB];
      head_id_nxt = mem_wdata[TAG_W +: ID_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ictr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ictr_r      <= ictr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    cidx_r    <= cidx_nxt;
    e_r       <= e_nxt;
    c_r       <= c_nxt;
    rvalid_r  <= rvalid_nxt;
    arm_r     <= arm_nxt;
    now_r     <= now_nxt;
    head_dl_r <= head_dl_nxt;
    head_id_r <= head_id_nxt;
    kind_r    <= kind_nxt;
    oid_r     <= oid_nxt;
    odl_r     <= odl_nxt;
    oarm_r    <= oarm_nxt;
    onext_r   <= onext_nxt;
    oempty_r  <= oempty_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.out_timer_id  = oid_r;
  assign out_ch.out_deadline  = odl_r;
  assign out_ch.arm_request   = oarm_r;
  assign out_ch.next_deadline = onext_r;
  assign out_ch.queue_empty   = oempty_r;
  assign out_ch.last          = olast_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("pending count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CW'(1) ||
                      cnt_r + CW'(1) == $past(cnt_r)))
    else $error("pending count moved by more than one");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(CAPACITY) && CW'(mem_waddr) < cnt_r))
    else $error("heap write outside the live entries");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the deadline timer queue: directed table, then random traffic
`timescale 1ns / 100ps

module tb_top;
  import dtq_pkg::*;

  localparam int CAP       = 32;
  localparam int WDOG_MAX  = 5000;
  localparam int DRAIN_CYC = 400;
  localparam logic [FIELD_TW-1:0] TMAX = {FIELD_TW{1'b1}};

  typedef struct packed {
    kind_t               kind;
    logic [ID_W-1:0]     tmr_id;
    logic [FIELD_TW-1:0] deadline;
    logic                arm;
    logic [FIELD_TW-1:0] next_dl;
    logic                empty;
    logic                last;
  } timer_result_t;

  typedef struct {
    cmd_t                cmd;
    logic [ID_W-1:0]     tmr_id;
    logic [FIELD_TW-1:0] deadline;
    logic [FIELD_TW-1:0] now_ms;
    bit                  typed;
    kind_t               t_kind;
    bit                  t_arm;
    bit                  t_empty;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  dtq_in_if  in_ch ();
  dtq_out_if out_ch ();

  deadline_timer_queue #(.CAPACITY(CAP), .TIME_BITS(FIELD_TW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // shadow heap
  logic [FIELD_TW-1:0] hp_dl  [CAP];
  logic [ID_W-1:0]     hp_id  [CAP];
  logic [TAG_W-1:0]    hp_tag [CAP];
  int unsigned         hp_count;
  logic [TAG_W-1:0]    push_seq;

  timer_result_t pending_results[$];
  int  errors;
  int  idle_pct, stall_pct;
  int  quiet_cycles;
  int  n_items, n_released, n_rejected;

  function automatic bit leaves_first(int a, int b);
    logic [TAG_W-1:0] diff;
    if (hp_dl[a] != hp_dl[b]) return hp_dl[a] < hp_dl[b];
    diff = hp_tag[a] - hp_tag[b];
    return diff[TAG_W-1];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [FIELD_TW-1:0] d;
    logic [ID_W-1:0]     i;
    logic [TAG_W-1:0]    t;
    d = hp_dl[a];  hp_dl[a]  = hp_dl[b];  hp_dl[b]  = d;
    i = hp_id[a];  hp_id[a]  = hp_id[b];  hp_id[b]  = i;
    t = hp_tag[a]; hp_tag[a] = hp_tag[b]; hp_tag[b] = t;
  endfunction

  function automatic logic [FIELD_TW-1:0] head_dl();
    return (hp_count != 0) ? hp_dl[0] : '0;
  endfunction

  // works out the results of one accepted item and queues them
  function automatic void predict_timers(cmd_t cmd, logic [ID_W-1:0] id,
                                         logic [FIELD_TW-1:0] dl,
                                         logic [FIELD_TW-1:0] now);
    timer_result_t r;
    int pos, par, l, rc, best;
    bit arm;
    if (cmd == CMD_PUSH) begin
      if (hp_count >= CAP) begin
        r = '{KIND_PUSH_FULL, id, dl, 1'b0, head_dl(), hp_count == 0, 1'b1};
        pending_results.push_back(r);
        n_rejected++;
        return;
      end
      arm = (hp_count == 0) || (dl < hp_dl[0]);
      pos = hp_count;
      hp_dl[pos] = dl; hp_id[pos] = id; hp_tag[pos] = push_seq;
      push_seq++;
      hp_count++;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!leaves_first(pos, par)) break;
        swap_entries(pos, par);
        pos = par;
      end
      r = '{KIND_PUSH_OK, id, dl, arm, head_dl(), 1'b0, 1'b1};
      pending_results.push_back(r);
      return;
    end
    while (hp_count > 0 && hp_dl[0] <= now) begin
      r = '{KIND_EXPIRED, hp_id[0], hp_dl[0], 1'b0, '0, 1'b0, 1'b0};
      pending_results.push_back(r);
      n_released++;
      hp_count--;
      if (hp_count > 0) begin
        swap_entries(0, hp_count);
        pos = 0;
        forever begin
          l = 2 * pos + 1; rc = l + 1; best = pos;
          if (l < hp_count && leaves_first(l, best)) best = l;
          if (rc < hp_count && leaves_first(rc, best)) best = rc;
          if (best == pos) break;
          swap_entries(pos, best);
          pos = best;
        end
      end
    end
    r = '{KIND_SUMMARY, '0, '0, hp_count != 0, head_dl(), hp_count == 0, 1'b1};
    pending_results.push_back(r);
  endfunction

  // sender: one transfer per call, idle gaps drawn from idle_pct
  task automatic send_timer_cmd(stim_row_t row);
    int gap;
    int first;
    timer_result_t r;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= row.cmd;
    in_ch.tmr_id   <= row.tmr_id;
    in_ch.deadline <= row.deadline;
    in_ch.now_ms   <= row.now_ms;
    do @(posedge clk); while (!in_ch.ready);
    first = pending_results.size();
    predict_timers(row.cmd, row.tmr_id, row.deadline, row.now_ms);
    n_items++;
    if (row.typed) begin
      // first result of this item carries hand-written values
      r = pending_results[first];
      r.kind  = row.t_kind;
      r.arm   = row.t_arm;
      r.empty = row.t_empty;
      pending_results[first] = r;
    end
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t mk(cmd_t c, logic [ID_W-1:0] id, logic [FIELD_TW-1:0] dl,
                                   logic [FIELD_TW-1:0] now);
    stim_row_t s;
    s = '{c, id, dl, now, 1'b0, KIND_PUSH_OK, 1'b0, 1'b0};
    return s;
  endfunction

  function automatic stim_row_t mkt(cmd_t c, logic [ID_W-1:0] id, logic [FIELD_TW-1:0] dl,
                                    logic [FIELD_TW-1:0] now, kind_t k, bit a, bit e);
    stim_row_t s;
    s = '{c, id, dl, now, 1'b1, k, a, e};
    return s;
  endfunction

  function automatic logic [FIELD_TW-1:0] wide_rand();
    return FIELD_TW'({$urandom, $urandom});
  endfunction

  // receiver and result check
  always @(posedge clk) begin
    timer_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result kind %0d with nothing expected", out_ch.kind);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.kind != e.kind) begin
          $error("kind: expected %0d got %0d", e.kind, out_ch.kind); errors++;
        end
        if (out_ch.out_timer_id != e.tmr_id) begin
          $error("out_timer_id: expected %h got %h", e.tmr_id, out_ch.out_timer_id);
          errors++;
        end
        if (out_ch.out_deadline != e.deadline) begin
          $error("out_deadline: expected %h got %h", e.deadline, out_ch.out_deadline);
          errors++;
        end
        if (out_ch.arm_request != e.arm) begin
          $error("arm_request: expected %b got %b", e.arm, out_ch.arm_request); errors++;
        end
        if (out_ch.next_deadline != e.next_dl) begin
          $error("next_deadline: expected %h got %h", e.next_dl, out_ch.next_deadline);
          errors++;
        end
        if (out_ch.queue_empty != e.empty) begin
          $error("queue_empty: expected %b got %b", e.empty, out_ch.queue_empty); errors++;
        end
        if (out_ch.last != e.last) begin
          $error("last: expected %b got %b", e.last, out_ch.last); errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("timeout: no transfer for %0d cycles", WDOG_MAX);
      $display("** deadline_timer_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t row;
    int ph, k, burst;
    logic [FIELD_TW-1:0] base;
    in_ch.valid = 1'b0; in_ch.cmd = CMD_PUSH; in_ch.tmr_id = '0;
    in_ch.deadline = '0; in_ch.now_ms = '0;
    errors = 0; idle_pct = 0; stall_pct = 0;
    n_items = 0; n_released = 0; n_rejected = 0;
    hp_count = 0; push_seq = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty queue, extremes, ties in push order
    dir_rows.push_back(mkt(CMD_EXPIRE, 16'h0000, '0, '0, KIND_SUMMARY, 1'b0, 1'b1));
    dir_rows.push_back(mkt(CMD_EXPIRE, 16'hffff, TMAX, TMAX, KIND_SUMMARY, 1'b0, 1'b1));
    dir_rows.push_back(mkt(CMD_PUSH, 16'h0000, TMAX, '0, KIND_PUSH_OK, 1'b1, 1'b0));
    dir_rows.push_back(mkt(CMD_PUSH, 16'hffff, '0, TMAX, KIND_PUSH_OK, 1'b1, 1'b0));
    dir_rows.push_back(mkt(CMD_PUSH, 16'h0001, '0, '0, KIND_PUSH_OK, 1'b0, 1'b0));
    dir_rows.push_back(mkt(CMD_PUSH, 16'h0002, 48'd100, '0, KIND_PUSH_OK, 1'b0, 1'b0));
    dir_rows.push_back(mk(CMD_PUSH, 16'h0003, 48'd100, '0));
    dir_rows.push_back(mk(CMD_PUSH, 16'h0004, 48'd50, '0));
    dir_rows.push_back(mk(CMD_EXPIRE, 16'h1234, 48'h5555, '0));
    dir_rows.push_back(mk(CMD_EXPIRE, '0, '0, 48'd99));
    dir_rows.push_back(mk(CMD_EXPIRE, '0, '0, 48'd100));
    dir_rows.push_back(mk(CMD_PUSH, 16'haaaa, 48'haaaa_aaaa_aaaa, '0));
    dir_rows.push_back(mk(CMD_PUSH, 16'h5555, 48'h5555_5555_5555, '0));
    dir_rows.push_back(mk(CMD_EXPIRE, '0, '0, TMAX - 1));
    dir_rows.push_back(mkt(CMD_EXPIRE, '0, '0, TMAX, KIND_EXPIRED, 1'b0, 1'b0));
    foreach (dir_rows[i]) send_timer_cmd(dir_rows[i]);

    // fill to capacity with many equal deadlines, then push into the full queue
    for (k = 0; k < CAP; k++)
      send_timer_cmd(mk(CMD_PUSH, k[15:0], 48'd7 + (k % 3), '0));
    send_timer_cmd(mkt(CMD_PUSH, 16'hbeef, '0, '0, KIND_PUSH_FULL, 1'b0, 1'b0));
    send_timer_cmd(mk(CMD_PUSH, 16'hffff, TMAX, '0));
    send_timer_cmd(mk(CMD_EXPIRE, '0, '0, TMAX));
    quiesce();

    // random traffic over four idle/stall phases
    base = 48'd1000;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      k = 0;
      while (k < 30) begin
        burst = $urandom_range(12, 1);
        repeat (burst) begin
          row = mk(CMD_PUSH, ID_W'($urandom), base + $urandom_range(63), '0);
          if ($urandom_range(9) == 0) row.deadline = wide_rand();
          send_timer_cmd(row);
          k++;
        end
        row = mk(CMD_EXPIRE, ID_W'($urandom), wide_rand(), base + $urandom_range(63));
        case ($urandom_range(19))
          0: row.now_ms = wide_rand();
          1: row.now_ms = TMAX;
          2: row.now_ms = '0;
          default: ;
        endcase
        send_timer_cmd(row);
        k++;
        if ($urandom_range(3) == 0) base = base + $urandom_range(64);
      end
      quiesce();
    end

    idle_pct = 0; stall_pct = 0;
    repeat (DRAIN_CYC) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("covered %0d items: %0d timers released, %0d pushes rejected as full,",
             n_items, n_released, n_rejected);
    $display("over no-idle, sender-idle, receiver-stall and mixed phases");
    if (errors == 0)
      $display("** deadline_timer_queue: PASSED **");
    else
      $display("** deadline_timer_queue: FAILED **");
    $finish;
  end

endmodule
